/* rtl/tlib_pkg.sv */
// Shared constants, codes and helper functions for the terminal line input buffer.
// No dependencies; imported by tlib_ram users and the top level.
`default_nettype none
package tlib_pkg;

  localparam int TERMINAL_COUNT = 8;
  localparam int RING_DEPTH     = 256;
  localparam int MAX_READ       = 64;

  localparam int TTY_W  = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int RAM_DEPTH = TERMINAL_COUNT * RING_DEPTH;
  localparam int RAM_AW = $clog2(RAM_DEPTH);

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [RAM_AW-1:0]  ram_addr_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic [CMD_W-1:0] CMD_KEY   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  localparam logic [CFG_W-1:0] CFG_ECHO_ENABLE = 1'b0;
  localparam logic [CFG_W-1:0] CFG_LINE_MODE   = 1'b1;

  localparam byte_t  KEY_NEWLINE   = 8'h0A;
  localparam byte_t  KEY_BACKSPACE = 8'h08;
  localparam byte_t  PRINT_LOW     = 8'h20;
  localparam byte_t  PRINT_END     = 8'h80;
  localparam count_t MAX_READ_C    = COUNT_W'(MAX_READ);

  localparam ptr_t      PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam ram_addr_t RING_SPAN = RAM_AW'(RING_DEPTH);

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  function automatic ram_addr_t ring_addr(input logic [TTY_W-1:0] t, input ptr_t p);
    return RAM_AW'(t) * RING_SPAN + RAM_AW'(p);
  endfunction

  function automatic logic echoable(input byte_t c);
    return (c == KEY_NEWLINE) || (c == KEY_BACKSPACE) || ((c >= PRINT_LOW) && (c < PRINT_END));
  endfunction

endpackage
`default_nettype wire

/* rtl/tlib_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module tlib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/tty_line_input_buffer_core.sv */
// Terminal line input buffer: per-terminal input rings in one shared RAM.
// Depends on tlib_pkg and tlib_ram.
//
//  channel | direction | handshake          | payload
//  in_     | in        | tvalid/tready      | tuser: command; tdata: tty, byte, read count
//  out_    | out       | tvalid/tready/last | tuser: kind; tdata: byte, status, byte count
//  cfg_    | in        | we                 | index, wdata
//
// One item at a time, taken only in the idle state. Open, close, key input and errors pass
// through the accept (idle) and execute states. A read goes through idle and execute to the
// data state for its first byte, then the wait and data states for each further byte: each
// byte is one ring RAM read followed by the tail update. Output stalls hold the block in place.
// Reset (rst_n, synchronous) clears pointers, opens all terminals, sets both modes.
`default_nettype none
module tty_line_input_buffer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  input  wire logic [23:0] in_tdata,   // tty_index[3:0], char_byte[11:4], read_count[18:12], zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic [15:0]      out_tdata,  // data_byte[7:0], status[8], byte_count[15:9]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [tlib_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [0:0]  cfg_wdata
);
  import tlib_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_RD_WAIT = 2'd2;
  localparam logic [1:0] S_RD_DATA = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [IDX_W-1:0]  tty_r;
  byte_t             chr_r;
  count_t            want_r;
  count_t            cnt_r, cnt_nxt;
  ptr_t              head_r [TERMINAL_COUNT];
  ptr_t              head_nxt [TERMINAL_COUNT];
  ptr_t              tail_r [TERMINAL_COUNT];
  ptr_t              tail_nxt [TERMINAL_COUNT];
  logic              active_r [TERMINAL_COUNT];
  logic              active_nxt [TERMINAL_COUNT];
  logic              echo_en_r, line_mode_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  byte_t             out_byte_r;
  logic              out_status_r;
  count_t            out_count_r;
  logic              out_last_r;

  logic              emit;
  logic [KIND_W-1:0] emit_kind;
  byte_t             emit_byte;
  logic              emit_status;
  count_t            emit_count;
  logic              emit_last;

  logic              in_xfer, out_free, bad_tty;
  logic [TTY_W-1:0]  tidx;
  ptr_t              cur_head, cur_tail, nx_ptr;
  ram_addr_t         ram_raddr, ram_waddr;
  logic              ram_we;
  byte_t             ram_rdata;
  count_t            in_count, n_next;
  logic              rd_stop;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign tidx      = tty_r[TTY_W-1:0];
  assign bad_tty   = {1'b0, tty_r} >= (IDX_W + 1)'(TERMINAL_COUNT);
  assign cur_head  = head_r[tidx];
  assign cur_tail  = tail_r[tidx];
  assign nx_ptr    = ptr_inc(cur_head);
  assign ram_raddr = ring_addr(tidx, cur_tail);
  assign ram_waddr = ring_addr(tidx, cur_head);
  assign in_count  = in_tdata[18:12];
  assign n_next    = cnt_r + COUNT_W'(1);

  tlib_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (chr_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    active_nxt  = active_r;
    ram_we      = 1'b0;
    emit        = 1'b0;
    emit_kind   = KIND_STATUS;
    emit_byte   = '0;
    emit_status = 1'b0;
    emit_count  = '0;
    emit_last   = 1'b1;
    rd_stop     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cnt_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (bad_tty) begin
            emit        = 1'b1;
            emit_status = 1'b1;
          end else begin
            unique case (cmd_r) inside
              CMD_OPEN, CMD_CLOSE: begin
                active_nxt[tidx] = (cmd_r == CMD_OPEN);
                emit             = 1'b1;
              end
              CMD_KEY: begin
                if (active_r[tidx]) begin
                  if (chr_r == KEY_BACKSPACE) begin
                    if (cur_head != cur_tail) begin
                      head_nxt[tidx] = ptr_dec(cur_head);
                      emit           = echo_en_r && echoable(chr_r);
                    end
                  end else if (nx_ptr != cur_tail) begin
                    ram_we         = 1'b1;
                    head_nxt[tidx] = nx_ptr;
                    emit           = echo_en_r && echoable(chr_r);
                  end
                  emit_kind = KIND_ECHO;
                  emit_byte = chr_r;
                end
              end
              CMD_READ: begin
                if (!active_r[tidx]) begin
                  emit        = 1'b1;
                  emit_status = 1'b1;
                end else if ((want_r == '0) || (cur_head == cur_tail)) begin
                  emit = 1'b1;
                end else begin
                  state_nxt = S_RD_DATA;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_RD_WAIT: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          rd_stop = (n_next == want_r) || (ptr_inc(cur_tail) == cur_head)
                    || (line_mode_r && (ram_rdata == KEY_NEWLINE));
          tail_nxt[tidx] = ptr_inc(cur_tail);
          cnt_nxt        = n_next;
          emit           = 1'b1;
          emit_kind      = KIND_DATA;
          emit_byte      = ram_rdata;
          emit_count     = n_next;
          emit_last      = rd_stop;
          state_nxt      = rd_stop ? S_IDLE : S_RD_WAIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      echo_en_r   <= 1'b1;
      line_mode_r <= 1'b1;
      for (int i = 0; i < TERMINAL_COUNT; i++) begin
        head_r[i]   <= '0;
        tail_r[i]   <= '0;
        active_r[i] <= 1'b1;
      end
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      active_r <= active_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ECHO_ENABLE: echo_en_r   <= cfg_wdata[0];
          CFG_LINE_MODE:   line_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= in_tuser;
      tty_r  <= in_tdata[3:0];
      chr_r  <= in_tdata[11:4];
      want_r <= (in_count > MAX_READ_C) ? MAX_READ_C : in_count;
    end
    if (emit) begin
      out_kind_r   <= emit_kind;
      out_byte_r   <= emit_byte;
      out_status_r <= emit_status;
      out_count_r  <= emit_count;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_count_r, out_status_r, out_byte_r};
  assign out_tlast  = out_last_r;

  a_rd_count_below_want: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_DATA) |-> (cnt_r < want_r))
    else $error("read continues past its byte limit");

  a_ram_write_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_EXEC) && out_free && (cmd_r == CMD_KEY)))
    else $error("ring write outside key handling");

  a_data_not_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (emit_kind == KIND_DATA) && !emit_last) |=> (state_r == S_RD_WAIT))
    else $error("read did not wait for the next ring byte");

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrites an untaken result");

endmodule
`default_nettype wire

/* tb/sv/tty_line_input_buffer_core_test.sv */
// Self-checking testbench for tty_line_input_buffer_core: stream stimulus, random backpressure,
// and a scoreboard fed by a behavioral predictor of the per-terminal input rings.
// Depends on tlib_pkg and the tty_line_input_buffer_core RTL.
module tty_line_input_buffer_core_test;
  import tlib_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SCRIPT_LEN  = 26;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    byte_t             data;
    logic              status;
    count_t            count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] tty;
    byte_t            ch;
    count_t           want;
    logic             typed;
    logic             err;
  } script_row_t;

  // typed rows expect a single status transfer with the given error bit
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_READ,  4'd0,  8'h00,         7'd5,   1'b1, 1'b0},
    '{CMD_KEY,   4'd8,  8'h41,         7'd0,   1'b1, 1'b1},
    '{CMD_READ,  4'd15, 8'hFF,         7'd127, 1'b1, 1'b1},
    '{CMD_CLOSE, 4'd9,  8'h00,         7'd0,   1'b1, 1'b1},
    '{CMD_CLOSE, 4'd7,  8'h00,         7'd0,   1'b1, 1'b0},
    '{CMD_KEY,   4'd7,  8'h7A,         7'd0,   1'b0, 1'b0},
    '{CMD_READ,  4'd7,  8'h00,         7'd10,  1'b1, 1'b1},
    '{CMD_OPEN,  4'd7,  8'h00,         7'd0,   1'b1, 1'b0},
    '{CMD_KEY,   4'd2,  KEY_BACKSPACE, 7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h20,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h7F,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h00,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'hFF,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h1F,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h80,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  KEY_NEWLINE,   7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h71,         7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  KEY_BACKSPACE, 7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  KEY_BACKSPACE, 7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  KEY_NEWLINE,   7'd0,   1'b0, 1'b0},
    '{CMD_KEY,   4'd0,  8'h72,         7'd0,   1'b0, 1'b0},
    '{CMD_READ,  4'd0,  8'h00,         7'd0,   1'b1, 1'b0},
    '{CMD_READ,  4'd0,  8'h00,         7'd127, 1'b0, 1'b0},
    '{CMD_READ,  4'd0,  8'h00,         7'd1,   1'b0, 1'b0},
    '{CMD_READ,  4'd0,  8'h00,         7'd64,  1'b0, 1'b0},
    '{CMD_KEY,   4'd7,  8'h6B,         7'd0,   1'b0, 1'b0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [1:0]          in_tuser;
  logic [23:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [1:0]          out_tuser;
  logic [15:0]         out_tdata;
  logic                out_tlast;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_index;
  logic [0:0]          cfg_wdata;

  byte_t   ring_copy [TERMINAL_COUNT][RING_DEPTH];
  int      head_at [TERMINAL_COUNT];
  int      tail_at [TERMINAL_COUNT];
  bit      tty_live [TERMINAL_COUNT];
  bit      echo_on;
  bit      line_on;
  result_t pending_results [$];
  result_t step_results [$];

  bit      in_accepted;
  bit      cur_typed;
  bit      cur_err;
  int      burst_left;
  int      quiet_cycles;
  int      mismatch_count;

  tty_line_input_buffer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_tty_results(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] tty,
                                              byte_t ch, count_t want);
    int      t;
    int      h;
    int      tl;
    int      nx;
    int      lim;
    int      n;
    byte_t   b;
    result_t r;
    step_results.delete();
    t = int'(tty);
    if (t >= TERMINAL_COUNT) begin
      step_results.push_back(result_t'{KIND_STATUS, 8'h00, 1'b1, 7'd0, 1'b1});
      return;
    end
    case (cmd)
      CMD_OPEN, CMD_CLOSE: begin
        tty_live[t] = (cmd == CMD_OPEN);
        step_results.push_back(result_t'{KIND_STATUS, 8'h00, 1'b0, 7'd0, 1'b1});
      end
      CMD_KEY: begin
        h  = head_at[t];
        tl = tail_at[t];
        if (!tty_live[t]) return;
        if (ch == KEY_BACKSPACE) begin
          if (h == tl) return;
          head_at[t] = (h + RING_DEPTH - 1) % RING_DEPTH;
        end else begin
          nx = (h + 1) % RING_DEPTH;
          if (nx == tl) return;
          ring_copy[t][h] = ch;
          head_at[t] = nx;
        end
        if (echo_on && (ch == KEY_NEWLINE || ch == KEY_BACKSPACE ||
                        (ch >= PRINT_LOW && ch < PRINT_END)))
          step_results.push_back(result_t'{KIND_ECHO, ch, 1'b0, 7'd0, 1'b1});
      end
      CMD_READ: begin
        if (!tty_live[t]) begin
          step_results.push_back(result_t'{KIND_STATUS, 8'h00, 1'b1, 7'd0, 1'b1});
          return;
        end
        lim = (int'(want) > MAX_READ) ? MAX_READ : int'(want);
        n = 0;
        while (n < lim && tail_at[t] != head_at[t]) begin
          b = ring_copy[t][tail_at[t]];
          tail_at[t] = (tail_at[t] + 1) % RING_DEPTH;
          n++;
          step_results.push_back(result_t'{KIND_DATA, b, 1'b0, count_t'(n), 1'b0});
          if (line_on && b == KEY_NEWLINE) break;
        end
        if (n == 0) begin
          step_results.push_back(result_t'{KIND_STATUS, 8'h00, 1'b0, 7'd0, 1'b1});
        end else begin
          r = step_results.pop_back();
          r.last = 1'b1;
          step_results.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic note_failure(input string msg);
    $display("%0t %s", $time, msg);
    mismatch_count++;
  endtask

  // scoreboard: check output transfers, predict on input transfers
  always @(posedge clk) begin
    result_t got;
    result_t want_r;
    in_accepted = in_tvalid && in_tready;
    if (out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[7:0], out_tdata[8], out_tdata[15:9], out_tlast};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected transfer kind %0d data %02h status %0d count %0d last %0d",
                               got.kind, got.data, got.status, got.count, got.last));
      end else begin
        want_r = pending_results.pop_front();
        if (got.kind !== want_r.kind || got.data !== want_r.data ||
            got.status !== want_r.status || got.count !== want_r.count ||
            got.last !== want_r.last)
          note_failure($sformatf({"mismatch got/exp kind %0d/%0d data %02h/%02h status %0d/%0d",
                                  " count %0d/%0d last %0d/%0d"},
                                 got.kind, want_r.kind, got.data, want_r.data,
                                 got.status, want_r.status, got.count, want_r.count,
                                 got.last, want_r.last));
      end
    end
    if (rst_n && in_accepted) begin
      predict_tty_results(in_tuser, in_tdata[3:0], in_tdata[11:4], in_tdata[18:12]);
      if (cur_typed)
        pending_results.push_back(result_t'{KIND_STATUS, 8'h00, cur_err, 7'd0, 1'b1});
      else
        foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver backpressure: the pattern is drawn at random from four modes
  initial begin
    int cyc;
    int mode;
    out_tready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 40 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 99) < 60);
        2: out_tready <= (cyc % 4 == 0);
        default: out_tready <= ((cyc % 40) >= 20);
      endcase
      cyc++;
    end
  end

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 99) < 5) gap = 15;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] tty,
                           input byte_t ch, input count_t want, input bit typed, input bit err);
    pace_sender();
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, want, ch, tty};
    cur_typed = typed;
    cur_err   = err;
    do @(negedge clk); while (!in_accepted);
  endtask

  // hold off until every expected transfer is in and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_modes(input bit echo_val, input bit line_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ECHO_ENABLE;
    cfg_wdata <= echo_val;
    @(negedge clk);
    cfg_index <= CFG_LINE_MODE;
    cfg_wdata <= line_val;
    @(negedge clk);
    cfg_we  <= 1'b0;
    echo_on = echo_val;
    line_on = line_val;
  endtask

  task automatic fill_and_drain(input logic [IDX_W-1:0] tty);
    byte_t ch;
    send_item(CMD_OPEN, tty, 8'h00, 7'd0, 1'b0, 1'b0);
    repeat (RING_DEPTH + 1) begin
      ch = byte_t'($urandom_range(0, 255));
      if (ch == KEY_BACKSPACE) ch = KEY_NEWLINE;
      send_item(CMD_KEY, tty, ch, 7'd0, 1'b0, 1'b0);
    end
    repeat (4) send_item(CMD_READ, tty, 8'h00, count_t'(MAX_READ), 1'b0, 1'b0);
  endtask

  task automatic run_mix(input int items);
    int               r;
    int               k;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] tty;
    byte_t            ch;
    count_t           want;
    repeat (items) begin
      r = $urandom_range(0, 99);
      tty = ($urandom_range(0, 99) < 70) ? IDX_W'($urandom_range(0, 2))
                                         : IDX_W'($urandom_range(0, TERMINAL_COUNT - 1));
      k = $urandom_range(0, 99);
      if (k < 45)      ch = byte_t'($urandom_range(PRINT_LOW, 8'h7E));
      else if (k < 60) ch = KEY_NEWLINE;
      else if (k < 75) ch = KEY_BACKSPACE;
      else             ch = byte_t'($urandom_range(0, 255));
      k = $urandom_range(0, 99);
      if (k < 50)      want = count_t'($urandom_range(1, 12));
      else if (k < 85) want = count_t'($urandom_range(0, 127));
      else             want = count_t'($urandom_range(MAX_READ - 4, MAX_READ));
      if (r < 55)      cmd = CMD_KEY;
      else if (r < 82) cmd = CMD_READ;
      else if (r < 88) cmd = CMD_OPEN;
      else if (r < 91) cmd = CMD_CLOSE;
      else begin
        cmd = CMD_W'($urandom_range(0, 3));
        tty = IDX_W'($urandom_range(TERMINAL_COUNT, 15));
      end
      send_item(cmd, tty, ch, want, 1'b0, 1'b0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = '0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    burst_left     = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    for (int i = 0; i < TERMINAL_COUNT; i++) begin
      head_at[i]  = 0;
      tail_at[i]  = 0;
      tty_live[i] = 1'b1;
    end
    echo_on = 1'b1;
    line_on = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_modes(1'b1, 1'b1);
    foreach (SCRIPT[i])
      send_item(SCRIPT[i].cmd, SCRIPT[i].tty, SCRIPT[i].ch, SCRIPT[i].want,
                SCRIPT[i].typed, SCRIPT[i].err);
    settle();

    set_modes(1'b1, 1'b0);
    fill_and_drain(IDX_W'(3));
    settle();

    set_modes(1'b0, 1'b0);
    run_mix(8);
    settle();

    set_modes(1'b0, 1'b1);
    run_mix(8);
    settle();

    set_modes(1'b1, 1'b1);
    run_mix(8);
    settle();

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/tlib_pkg.sv
rtl/tlib_ram.sv
rtl/tty_line_input_buffer_core.sv
tb/sv/tty_line_input_buffer_core_test.sv
